FILE: hdl/lic_pkg.sv
// Shared types, codes and constants of the leak interlock controller.
package lic_pkg;

    localparam int TIME_W     = 32;
    localparam int COOL_W     = 16;
    localparam int MASK_W     = 3;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int REQ_W      = 2;
    localparam int KIND_W     = 2;
    localparam int LOCK_W     = 2;
    localparam int EVENT_W    = 3;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 48;

    localparam logic              AUTO_EN_RST  = 1'b1;
    localparam logic [MASK_W-1:0] MASK_RST     = 3'd7;
    localparam logic [COOL_W-1:0] COOLDOWN_RST = 16'd10000;
    localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd300000;

    typedef enum logic [REQ_W-1:0] {
        REQ_LEAK,
        REQ_TICK,
        REQ_RESET,
        REQ_RECONNECT
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        SRC_BLE,
        SRC_LORA,
        SRC_FLOOD,
        SRC_UNKNOWN
    } t_kind;

    typedef enum logic [LOCK_W-1:0] {
        LOCK_NONE,
        LOCK_SET,
        LOCK_CLEAR
    } t_lock;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE,
        EV_AUTO_CLOSE,
        EV_RESET_CLEARED,
        EV_AUTO_CLEARED,
        EV_OVERRIDE
    } t_event;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AUTO_EN,
        CFG_MASK,
        CFG_COOLDOWN,
        CFG_TIMEOUT
    } t_cfg_addr;

    // Command from the interlock core to the sensor table.
    typedef struct packed {
        logic go;
        logic clear;
        logic leak;
    } t_tbl_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_APPLY
    } t_state;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_SCAN,
        TS_SHIFT,
        TS_DONE
    } t_tbl_state;

endpackage

FILE: hdl/lic_id_mem.sv
// Simple dual-port memory holding the codes of the leaking sensors.
module lic_id_mem #(
    parameter int DEPTH = lic_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = lic_pkg::ID_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lic_table.sv
// Sensor table sequencer: linear search, append and compaction over the code memory.
module lic_table #(
    parameter int TABLE_DEPTH = lic_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BITS     = lic_pkg::ID_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lic_pkg::t_tbl_req                i_req,
    input  logic [ID_BITS-1:0]               i_code,
    output logic                             o_done,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_total
);
    import lic_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_tbl_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_total, n_total;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ID_BITS-1:0] mem_rdata;

    logic hit;
    logic more;
    logic room;

    lic_id_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ID_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The read data always belongs to entry r_idx while scanning or shifting.
    assign hit  = (mem_rdata == i_code);
    assign more = ((CNT_W'(r_idx) + CNT_W'(1)) < r_total);
    assign room = (r_total < CNT_W'(TABLE_DEPTH));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: begin
                if (i_req.go) begin
                    n_state = (r_total == '0) ? TS_DONE : TS_SCAN;
                end
            end
            TS_SCAN: begin
                if (hit) begin
                    n_state = (!i_req.leak && more) ? TS_SHIFT : TS_DONE;
                end else if (!more) begin
                    n_state = TS_DONE;
                end
            end
            TS_SHIFT: begin
                if (!more) begin
                    n_state = TS_DONE;
                end
            end
            TS_DONE: begin
                n_state = TS_IDLE;
            end
            default: begin
                n_state = TS_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_total   = r_total;
        mem_we    = 1'b0;
        mem_waddr = r_total[IDX_W-1:0];
        mem_wdata = i_code;
        mem_raddr = r_idx + IDX_W'(1);
        o_done    = 1'b0;
        unique case (r_state)
            TS_IDLE: begin
                mem_raddr = '0;
                n_idx     = '0;
                if (i_req.clear) begin
                    n_total = '0;
                end else if (i_req.go && r_total == '0 && i_req.leak) begin
                    mem_we  = 1'b1;
                    n_total = r_total + CNT_W'(1);
                end
            end
            TS_SCAN: begin
                if (hit) begin
                    if (!i_req.leak) begin
                        if (more) begin
                            n_idx = r_idx + IDX_W'(1);
                        end else begin
                            n_total = r_total - CNT_W'(1);
                        end
                    end
                end else if (more) begin
                    n_idx = r_idx + IDX_W'(1);
                end else if (i_req.leak && room) begin
                    mem_we  = 1'b1;
                    n_total = r_total + CNT_W'(1);
                end
            end
            TS_SHIFT: begin
                // Move entry r_idx down by one while the next one is fetched.
                mem_we    = 1'b1;
                mem_waddr = r_idx - IDX_W'(1);
                mem_wdata = mem_rdata;
                if (more) begin
                    n_idx = r_idx + IDX_W'(1);
                end else begin
                    n_total = r_total - CNT_W'(1);
                end
            end
            TS_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TS_IDLE;
            r_total <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_idx   <= n_idx;
        end
    end

    assign o_total = r_total;

endmodule

FILE: hdl/leak_interlock_controller.sv
// Leak interlock controller top level: request decode, latches, timers and result register.
//
//  channel   | direction | handshake                    | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser req_type, tdata report fields
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata result fields
//  cfg       | in        | i_cfg_we                      | i_cfg_addr, i_cfg_wdata
//
// A tick, reset, reconnect or code-less report request goes from acceptance straight to ST_APPLY,
// where its result is loaded once the result register is free; the block then returns to idle.
// A leak report with a sensor code first passes through ST_START and ST_WAIT while the sequencer
// scans and compacts the code memory one entry per cycle, so its wait grows with the table fill.
// The result register lets the next request be accepted while a result waits; that request
// then stalls until the waiting result is taken.
// Reset is synchronous; it empties the table and restores the register defaults.
module leak_interlock_controller #(
    parameter int TABLE_DEPTH = lic_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BITS     = lic_pkg::ID_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // source_kind, leak_detected, sensor_code, code_present, is_provisioned,
    // valve_closed, valve_lock_set, zero fill
    input  logic [((ID_BITS+14)/8)*8-1:0]           s_axis_tdata,
    // req_type
    input  logic [lic_pkg::REQ_W-1:0]               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // close_cmd, lock_cmd, event_code, incident_flag, override_flag,
    // leaking_count, zero fill
    output logic [((15+$clog2(TABLE_DEPTH+1))/8)*8-1:0] m_axis_tdata,
    input  logic                                    i_cfg_we,
    input  logic [lic_pkg::CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [lic_pkg::CFG_W-1:0]               i_cfg_wdata
);
    import lic_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Configuration.
    logic              r_auto_en;
    logic [MASK_W-1:0] r_mask;
    logic [COOL_W-1:0] r_cooldown;
    logic [TIME_W-1:0] r_timeout;

    // Captured request.
    t_req               r_req;
    t_kind              r_kind;
    logic               r_leak;
    logic [ID_BITS-1:0] r_code;
    logic               r_present;
    logic               r_prov;
    logic               r_vclosed;
    logic               r_vlock;

    // Interlock state.
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_last_close, n_last_close;
    logic [TIME_W-1:0] r_quiet_start, n_quiet_start;
    logic              r_quiet, n_quiet;
    logic              r_closed_before, n_closed_before;
    logic              r_incident, n_incident;
    logic              r_override, n_override;

    // Result register.
    logic             r_out_valid;
    logic             r_o_close, n_o_close;
    t_lock            r_o_lock, n_o_lock;
    t_event           r_o_event, n_o_event;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;

    t_state r_state, n_state;

    t_tbl_req         tbl_req;
    logic             tbl_done;
    logic [CNT_W-1:0] tbl_total;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [3:0]        trig_bits;
    logic [TIME_W-1:0] since_close;
    logic [TIME_W-1:0] quiet_elapsed;

    lic_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .i_code  (r_code),
        .o_done  (tbl_done),
        .o_total (tbl_total)
    );

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (t_req'(s_axis_tuser) == REQ_LEAK && s_axis_tdata[ID_BITS+3]) begin
                        n_state = ST_START;
                    end else begin
                        n_state = ST_APPLY;
                    end
                end
            end
            ST_START: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (tbl_done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        out_load      = (r_state == ST_APPLY) && out_free;
        tbl_req.go    = (r_state == ST_START);
        tbl_req.clear = out_load && (r_req == REQ_RESET);
        tbl_req.leak  = r_leak;
    end

    assign trig_bits     = {1'b0, r_mask};
    assign since_close   = r_now - r_last_close;
    assign quiet_elapsed = r_now - r_quiet_start;

    // Effects of one request; a coded leak report's table update is done when this is used.
    always_comb begin
        n_last_close    = r_last_close;
        n_quiet_start   = r_quiet_start;
        n_quiet         = r_quiet;
        n_closed_before = r_closed_before;
        n_incident      = r_incident;
        n_override      = r_override;
        n_o_close       = 1'b0;
        n_o_lock        = LOCK_NONE;
        n_o_event       = EV_NONE;
        n_o_cnt         = tbl_total;
        case (r_req)
            REQ_LEAK: begin
                if (r_present) begin
                    if (r_leak) begin
                        n_quiet = 1'b0;
                    end else if (tbl_total == '0) begin
                        n_override = 1'b0;
                        if (r_incident && !r_quiet) begin
                            n_quiet       = 1'b1;
                            n_quiet_start = r_now;
                        end
                    end
                end
                if (r_leak && r_prov && r_auto_en && trig_bits[r_kind] && !n_override) begin
                    n_incident = 1'b1;
                    if (!(r_vclosed && r_vlock) &&
                        !(r_closed_before && since_close < TIME_W'(r_cooldown))) begin
                        n_closed_before = 1'b1;
                        n_last_close    = r_now;
                        n_o_close       = 1'b1;
                        n_o_lock        = LOCK_SET;
                        n_o_event       = EV_AUTO_CLOSE;
                    end
                end
            end
            REQ_TICK: begin
                // r_now already holds the advanced time here.
                if (r_incident) begin
                    if (r_quiet && quiet_elapsed >= r_timeout) begin
                        n_incident      = 1'b0;
                        n_closed_before = 1'b0;
                        n_quiet         = 1'b0;
                        n_o_lock        = LOCK_CLEAR;
                        n_o_event       = EV_AUTO_CLEARED;
                    end else if (!r_vlock) begin
                        n_incident      = 1'b0;
                        n_closed_before = 1'b0;
                        n_quiet         = 1'b0;
                        n_override      = 1'b1;
                        n_o_event       = EV_OVERRIDE;
                    end
                end
            end
            REQ_RESET: begin
                n_incident      = 1'b0;
                n_closed_before = 1'b0;
                n_override      = 1'b0;
                n_quiet         = 1'b0;
                n_o_cnt         = '0;
                if (r_incident || r_vlock) begin
                    n_o_lock  = LOCK_CLEAR;
                    n_o_event = EV_RESET_CLEARED;
                end
            end
            default: begin
                if (r_incident && !r_vlock) begin
                    n_o_lock = LOCK_SET;
                end else if (!r_incident && r_vlock) begin
                    n_incident = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_en  <= AUTO_EN_RST;
            r_mask     <= MASK_RST;
            r_cooldown <= COOLDOWN_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_AUTO_EN:  r_auto_en  <= i_cfg_wdata[0];
                CFG_MASK:     r_mask     <= i_cfg_wdata[MASK_W-1:0];
                CFG_COOLDOWN: r_cooldown <= i_cfg_wdata[COOL_W-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata[TIME_W-1:0];
                default:      r_auto_en  <= r_auto_en;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= t_req'(s_axis_tuser);
            r_kind    <= t_kind'(s_axis_tdata[1:0]);
            r_leak    <= s_axis_tdata[2];
            r_code    <= s_axis_tdata[ID_BITS+2:3];
            r_present <= s_axis_tdata[ID_BITS+3];
            r_prov    <= s_axis_tdata[ID_BITS+4];
            r_vclosed <= s_axis_tdata[ID_BITS+5];
            r_vlock   <= s_axis_tdata[ID_BITS+6];
        end
        if (out_load) begin
            r_o_close <= n_o_close;
            r_o_lock  <= n_o_lock;
            r_o_event <= n_o_event;
            r_o_cnt   <= n_o_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_now           <= '0;
            r_last_close    <= '0;
            r_quiet_start   <= '0;
            r_quiet         <= 1'b0;
            r_closed_before <= 1'b0;
            r_incident      <= 1'b0;
            r_override      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            // Time advances as soon as a tick request is taken in.
            if (accept && t_req'(s_axis_tuser) == REQ_TICK) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (out_load) begin
                r_last_close    <= n_last_close;
                r_quiet_start   <= n_quiet_start;
                r_quiet         <= n_quiet;
                r_closed_before <= n_closed_before;
                r_incident      <= n_incident;
                r_override      <= n_override;
                r_out_valid     <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata             = '0;
        m_axis_tdata[0]          = r_o_close;
        m_axis_tdata[2:1]        = r_o_lock;
        m_axis_tdata[5:3]        = r_o_event;
        m_axis_tdata[6]          = r_incident;
        m_axis_tdata[7]          = r_override;
        m_axis_tdata[8 +: CNT_W] = r_o_cnt;
    end

endmodule

FILE: tb/tb_leak_interlock_controller.sv
// Self-checking testbench for the leak interlock controller: directed and random requests, checked against a built-in predictor.
module tb_leak_interlock_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import lic_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int ID_W           = ID_BITS_DEF;
    localparam int IN_W           = ((ID_W + 14) / 8) * 8;
    localparam int OUT_W          = ((15 + $clog2(DEPTH + 1)) / 8) * 8;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int CODE_POOL      = 24;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int N_PHASES       = 8;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_GAP      = 30;
    localparam int END_WAIT       = 5000;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int MAX_PRINTED    = 40;

    localparam bit [ID_W-1:0] CODE_ZERO = '0;
    localparam bit [ID_W-1:0] CODE_ONES = '1;
    localparam bit [ID_W-1:0] CODE_ALT  = {(ID_W / 2){2'b10}};

    typedef struct {
        t_req            req;
        t_kind           kind;
        bit              leak;
        bit [ID_W-1:0]   code;
        bit              has_code;
        bit              prov;
        bit              vclosed;
        bit              vlock;
    } t_valve_request;

    typedef struct {
        bit     close;
        t_lock  lock;
        t_event ev;
        bit     incident;
        bit     overridden;
        bit [4:0] count;
    } t_valve_outcome;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;

    // Register copies and interlock state of the predictor.
    bit              cfg_auto_en;
    bit [MASK_W-1:0] cfg_mask;
    bit [COOL_W-1:0] cfg_cooldown;
    bit [TIME_W-1:0] cfg_timeout;
    bit [TIME_W-1:0] now_t;
    bit [TIME_W-1:0] last_close_t;
    bit [TIME_W-1:0] quiet_start_t;
    bit              quiet_on;
    bit              closed_once;
    bit              incident_latched;
    bit              override_latched;
    bit [ID_W-1:0]   leak_ids [DEPTH];
    int              n_leaking;

    bit [ID_W-1:0]   code_pool [CODE_POOL];
    t_valve_outcome  expected_outcomes [$];

    int src_idle_pct;
    int snk_idle_pct;
    bit hold_request;
    int hold_left;
    int n_sent;
    int n_checked;
    int n_errors;
    int n_cycles;
    int n_closes;
    int n_auto_clears;
    int n_overrides;
    int n_dropped;

    leak_interlock_controller #(
        .TABLE_DEPTH (DEPTH),
        .ID_BITS     (ID_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Leaking-sensor table: insert on a leak, remove and compact on a clear.
    function automatic void track_sensor(bit [ID_W-1:0] code, bit leaking);
        int i;
        int pos;
        pos = -1;
        for (i = 0; i < n_leaking; i++) begin
            if (pos < 0 && leak_ids[i] == code) pos = i;
        end
        if (leaking) begin
            if (pos < 0) begin
                if (n_leaking < DEPTH) begin
                    leak_ids[n_leaking] = code;
                    n_leaking++;
                end else begin
                    n_dropped++;
                end
            end
            quiet_on = 1'b0;
            return;
        end
        if (pos >= 0) begin
            for (i = pos; i < n_leaking - 1; i++) leak_ids[i] = leak_ids[i + 1];
            n_leaking--;
        end
        if (n_leaking == 0) begin
            override_latched = 1'b0;
            if (incident_latched && !quiet_on) begin
                quiet_on      = 1'b1;
                quiet_start_t = now_t;
            end
        end
    endfunction

    function automatic t_valve_outcome predict_interlock(t_valve_request rq);
        t_valve_outcome res;
        bit was_latched;
        res.close = 1'b0;
        res.lock  = LOCK_NONE;
        res.ev    = EV_NONE;
        case (rq.req)
            REQ_LEAK: begin
                if (rq.has_code) track_sensor(rq.code, rq.leak);
                if (rq.leak && rq.prov && cfg_auto_en && rq.kind != SRC_UNKNOWN &&
                    cfg_mask[rq.kind] && !override_latched) begin
                    incident_latched = 1'b1;
                    if (!(rq.vclosed && rq.vlock) &&
                        !(closed_once && (now_t - last_close_t) < {16'h0, cfg_cooldown})) begin
                        closed_once  = 1'b1;
                        last_close_t = now_t;
                        res.close    = 1'b1;
                        res.lock     = LOCK_SET;
                        res.ev       = EV_AUTO_CLOSE;
                        n_closes++;
                    end
                end
            end
            REQ_TICK: begin
                now_t = now_t + 1;
                if (incident_latched) begin
                    if (quiet_on && (now_t - quiet_start_t) >= cfg_timeout) begin
                        incident_latched = 1'b0;
                        closed_once      = 1'b0;
                        quiet_on         = 1'b0;
                        res.lock         = LOCK_CLEAR;
                        res.ev           = EV_AUTO_CLEARED;
                        n_auto_clears++;
                    end else if (!rq.vlock) begin
                        // Someone unlocked the valve by hand: stand down.
                        incident_latched = 1'b0;
                        closed_once      = 1'b0;
                        quiet_on         = 1'b0;
                        override_latched = 1'b1;
                        res.ev           = EV_OVERRIDE;
                        n_overrides++;
                    end
                end
            end
            REQ_RESET: begin
                was_latched      = incident_latched;
                incident_latched = 1'b0;
                closed_once      = 1'b0;
                override_latched = 1'b0;
                quiet_on         = 1'b0;
                n_leaking        = 0;
                if (was_latched || rq.vlock) begin
                    res.lock = LOCK_CLEAR;
                    res.ev   = EV_RESET_CLEARED;
                end
            end
            default: begin
                if (incident_latched && !rq.vlock) res.lock = LOCK_SET;
                else if (!incident_latched && rq.vlock) incident_latched = 1'b1;
            end
        endcase
        res.incident   = incident_latched;
        res.overridden = override_latched;
        res.count      = n_leaking[4:0];
        return res;
    endfunction

    function automatic t_valve_request random_request();
        t_valve_request rq;
        rq.req      = t_req'($urandom_range(3));
        rq.kind     = t_kind'($urandom_range(3));
        rq.leak     = chance(50);
        rq.code     = chance(50) ? code_pool[$urandom_range(CODE_POOL - 1)]
                                 : {16'($urandom()), $urandom()};
        rq.has_code = chance(50);
        rq.prov     = chance(50);
        rq.vclosed  = chance(50);
        rq.vlock    = chance(50);
        return rq;
    endfunction

    // Tick, reset or reconnect; the report fields it carries are don't-cares, but for the valve lock.
    function automatic t_valve_request control_req(t_req req, bit vlock);
        t_valve_request rq;
        rq       = random_request();
        rq.req   = req;
        rq.vlock = vlock;
        return rq;
    endfunction

    function automatic t_valve_request report_req(t_kind kind, bit leak, bit [ID_W-1:0] code,
                                                  bit has_code, bit prov, bit vclosed, bit vlock);
        t_valve_request rq;
        rq.req      = REQ_LEAK;
        rq.kind     = kind;
        rq.leak     = leak;
        rq.code     = code;
        rq.has_code = has_code;
        rq.prov     = prov;
        rq.vclosed  = vclosed;
        rq.vlock    = vlock;
        return rq;
    endfunction

    function automatic t_kind trigger_kind();
        return chance(80) ? t_kind'($urandom_range(2)) : t_kind'($urandom_range(3));
    endfunction

    function automatic void set_idle(int mode);
        case (mode)
            0: begin src_idle_pct = 24; snk_idle_pct = 47; end
            1: begin src_idle_pct = 47; snk_idle_pct = 24; end
            default: begin src_idle_pct = 0; snk_idle_pct = 0; end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("Mismatch in %s at result %0d: got %0h, expected %0h",
                     what, n_checked, got, want);
    endtask

    // Offers one request, possibly after a random gap, and records its outcome once taken.
    task automatic send_request(t_valve_request rq);
        while (chance(src_idle_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.req;
        s_axis_tdata  <= {1'b0, rq.vlock, rq.vclosed, rq.prov, rq.has_code,
                          rq.code, rq.leak, rq.kind};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_outcomes.push_back(predict_interlock(rq));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    // Registers go in back to back, one per cycle, in index order.
    task automatic load_settings(logic [31:0] en, logic [31:0] mask,
                                 logic [31:0] cool, logic [31:0] tmo);
        logic [31:0] vals [4];
        t_cfg_addr reg_sel;
        vals    = '{en, mask, cool, tmo};
        reg_sel = CFG_AUTO_EN;
        repeat (4) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= reg_sel;
            i_cfg_wdata <= vals[reg_sel];
            @(negedge i_clk);
            reg_sel = reg_sel.next();
        end
        i_cfg_we     <= 1'b0;
        cfg_auto_en  = en[0];
        cfg_mask     = mask[MASK_W-1:0];
        cfg_cooldown = cool[COOL_W-1:0];
        cfg_timeout  = tmo;
        @(negedge i_clk);
    endtask

    // A leak on a few sensors, some time passing, the sensors clearing, then a quiet spell.
    task automatic run_episode();
        bit [ID_W-1:0] codes [3];
        int n_codes;
        int k;
        int span;
        n_codes = $urandom_range(1, 3);
        for (k = 0; k < n_codes; k++) codes[k] = code_pool[$urandom_range(CODE_POOL - 1)];
        for (k = 0; k < n_codes; k++) begin
            send_request(report_req(trigger_kind(), 1'b1, codes[k], chance(95), chance(90),
                                    chance(50), chance(50)));
            repeat ($urandom_range(3)) send_request(control_req(REQ_TICK, chance(85)));
            if (chance(20)) send_request(control_req(REQ_RECONNECT, chance(50)));
        end
        for (k = 0; k < n_codes; k++)
            send_request(report_req(t_kind'($urandom_range(3)), 1'b0, codes[k], chance(95),
                                    chance(50), chance(50), chance(50)));
        span = (cfg_timeout < 30) ? int'(cfg_timeout) + 3 : 30;
        repeat ($urandom_range(span)) send_request(control_req(REQ_TICK, chance(90)));
        if (chance(15)) send_request(control_req(REQ_RESET, chance(50)));
    endtask

    // Many distinct sensors leak at once, usually more than the table holds.
    task automatic flood_table();
        int n;
        int start;
        int k;
        n     = $urandom_range(14, 20);
        start = $urandom_range(CODE_POOL - 1);
        for (k = 0; k < n; k++)
            send_request(report_req(trigger_kind(), 1'b1, code_pool[(start + k) % CODE_POOL],
                                    1'b1, chance(70), chance(50), chance(50)));
        if (chance(60)) send_request(control_req(REQ_RESET, chance(50)));
    endtask

    task automatic test_directed_cases();
        set_idle(0);
        send_request(control_req(REQ_RESET, 1'b0));
        send_request(control_req(REQ_RESET, 1'b1));
        // A locked valve on reconnect re-latches the incident.
        send_request(control_req(REQ_RECONNECT, 1'b1));
        send_request(control_req(REQ_RECONNECT, 1'b0));
        send_request(control_req(REQ_TICK, 1'b0));
        send_request(report_req(SRC_BLE, 1'b1, CODE_ZERO, 1'b1, 1'b1, 1'b0, 1'b0));
        send_request(report_req(SRC_BLE, 1'b0, CODE_ZERO, 1'b1, 1'b1, 1'b0, 1'b0));
        send_request(report_req(SRC_UNKNOWN, 1'b1, CODE_ONES, 1'b1, 1'b1, 1'b0, 1'b0));
        send_request(report_req(SRC_LORA, 1'b1, CODE_ONES, 1'b1, 1'b0, 1'b0, 1'b0));
        send_request(report_req(SRC_FLOOD, 1'b0, CODE_ONES, 1'b1, 1'b1, 1'b0, 1'b0));
        // No sensor code, and the valve already closed and locked.
        send_request(report_req(SRC_FLOOD, 1'b1, CODE_ALT, 1'b0, 1'b1, 1'b1, 1'b1));
        send_request(report_req(SRC_BLE, 1'b1, CODE_ONES, 1'b1, 1'b1, 1'b0, 1'b1));
        send_request(report_req(SRC_LORA, 1'b1, CODE_ALT, 1'b1, 1'b1, 1'b0, 1'b0));
        send_request(report_req(SRC_BLE, 1'b0, CODE_ONES, 1'b1, 1'b1, 1'b1, 1'b0));
        send_request(report_req(SRC_LORA, 1'b0, CODE_ALT, 1'b1, 1'b0, 1'b0, 1'b1));
        send_request(control_req(REQ_TICK, 1'b1));
        send_request(control_req(REQ_TICK, 1'b0));
        send_request(report_req(SRC_FLOOD, 1'b1, CODE_ALT, 1'b1, 1'b1, 1'b0, 1'b0));
        send_request(control_req(REQ_RESET, 1'b0));
    endtask

    task automatic test_random_settings();
        int ph;
        int stop_at;
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: load_settings(1, 7, 0, 0);
                1: load_settings(1, 7, 5, 8);
                2: load_settings(1, 5, 20, 3);
                3: load_settings(0, 7, 2, 4);
                4: load_settings(1, 0, 3, 2);
                5: load_settings(1, 7, 65535, 32'hFFFF_FFFF);
                6: load_settings(1, 2, 1, 1);
                // Upper bits above each register's width must be dropped.
                default: load_settings($urandom(), $urandom(),
                                       ($urandom() & 32'hFFFF_0000) | $urandom_range(40),
                                       $urandom_range(25));
            endcase
            set_idle(ph % 3);
            stop_at = n_sent + RANDOM_ITEMS / N_PHASES;
            while (n_sent < stop_at) begin
                if (chance(25)) send_request(random_request());
                else if (chance(10)) flood_table();
                else run_episode();
            end
        end
    endtask

    // The receiver stops for a long while so the block fills and holds off new requests.
    task automatic test_output_backpressure();
        int k;
        drain_results();
        load_settings(1, 7, 4, 6);
        set_idle(2);
        @(posedge i_clk);
        hold_request = 1'b1;
        @(negedge i_clk);
        for (k = 0; k < 40; k++) begin
            if (chance(50)) send_request(random_request());
            else send_request(control_req(REQ_TICK, chance(80)));
        end
        drain_results();
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLDOFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !chance(snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_valve_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_axis_tdata), 64'(0));
            end else begin
                want = expected_outcomes.pop_front();
                if (m_axis_tdata[0] !== want.close)
                    report_mismatch("close_cmd", 64'(m_axis_tdata[0]), 64'(want.close));
                if (m_axis_tdata[2:1] !== want.lock)
                    report_mismatch("lock_cmd", 64'(m_axis_tdata[2:1]), 64'(want.lock));
                if (m_axis_tdata[5:3] !== want.ev)
                    report_mismatch("event_code", 64'(m_axis_tdata[5:3]), 64'(want.ev));
                if (m_axis_tdata[6] !== want.incident)
                    report_mismatch("incident_flag", 64'(m_axis_tdata[6]),
                                    64'(want.incident));
                if (m_axis_tdata[7] !== want.overridden)
                    report_mismatch("override_flag", 64'(m_axis_tdata[7]),
                                    64'(want.overridden));
                if (m_axis_tdata[12:8] !== want.count)
                    report_mismatch("leaking_count", 64'(m_axis_tdata[12:8]),
                                    64'(want.count));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     n_cycles, expected_outcomes.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int k;
        cfg_auto_en      = AUTO_EN_RST;
        cfg_mask         = MASK_RST;
        cfg_cooldown     = COOLDOWN_RST;
        cfg_timeout      = TIMEOUT_RST;
        now_t            = '0;
        last_close_t     = '0;
        quiet_start_t    = '0;
        quiet_on         = 1'b0;
        closed_once      = 1'b0;
        incident_latched = 1'b0;
        override_latched = 1'b0;
        n_leaking        = 0;
        code_pool[0]     = CODE_ZERO;
        code_pool[1]     = CODE_ONES;
        for (k = 2; k < CODE_POOL; k++) code_pool[k] = {16'($urandom()), $urandom()};
        set_idle(2);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_settings();
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        for (k = 0; k < END_WAIT && expected_outcomes.size() != 0; k++) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
        if (expected_outcomes.size() != 0)
            report_mismatch("missing results", 64'(expected_outcomes.size()), 64'(0));

        $display("Checked %0d results for %0d requests across %0d register settings.",
                 n_checked, n_sent, N_PHASES + 2);
        $display("Seen: %0d auto-closes, %0d auto-clears, %0d overrides, %0d full-table drops.",
                 n_closes, n_auto_clears, n_overrides, n_dropped);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
